// ===== rtl/core/sia_pkg.sv =====
// ----------------------------------------------------------------------------
// sia_pkg
// Shared types and constants of the stable integer argsort block.
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int KEY_W         = 32;
  localparam int INDEX_W       = 6;
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  // Register index, taken from paddr[APB_AW-1] (byte address 4*i).
  localparam logic REG_DESCENDING = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;       // write the accepted key, or note a drop
    logic rd_sel_i;    // key memory read address: 1 = outer index, 0 = scan index
    logic j_clr;
    logic j_inc;
    logic rank_clr;
    logic latch_key;
    logic cmp_en;
    logic idx_wr;
    logic i_inc;
    logic out_load;
    logic out_clear;
    logic k_inc;
    logic list_done;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cmp_last;
    logic i_last;
    logic k_last;
  } status_t;

endpackage

// ===== rtl/core/sia_ram.sv =====
// ----------------------------------------------------------------------------
// sia_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sia_dp.sv =====
// ----------------------------------------------------------------------------
// sia_dp
// Datapath: key and rank memories, counters, comparator and output register.
// ----------------------------------------------------------------------------
module sia_dp import sia_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [KEY_W-1:0]   value_i,
  input  logic               descending_i,
  output logic               out_valid_o,
  output logic [INDEX_W-1:0] index_o,
  output logic               last_out_o,
  output logic               overflow_o
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  logic [CW-1:0]      cnt_q, cnt_d;
  logic               drop_q, drop_d;
  logic [AW-1:0]      i_q, i_d;
  logic [CW-1:0]      j_q, j_d;
  logic [AW-1:0]      k_q, k_d;
  logic [AW-1:0]      rank_q, rank_d;
  logic [KEY_W-1:0]   keyi_q;
  logic               out_valid_q, out_valid_d;
  logic [INDEX_W-1:0] out_idx_q;
  logic               out_last_q;
  logic               out_ovf_q;

  logic               key_we;
  logic [AW-1:0]      key_raddr;
  logic [KEY_W-1:0]   key_rdata;
  logic [AW-1:0]      idx_rdata;

  logic signed [KEY_W-1:0] kj, ki;
  logic               strictly_before, equal_keys, arrived_earlier;
  logic [CW-1:0]      j_m1;
  logic [CW-1:0]      cnt_m1;

  assign key_we    = cmd_i.store && (cnt_q < MAX_CNT);
  assign key_raddr = cmd_i.rd_sel_i ? i_q : j_q[AW-1:0];

  sia_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ITEMS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (value_i),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  // The rank memory maps each sorted position to the arrival index.
  sia_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_ITEMS)
  ) u_idx_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.idx_wr),
    .waddr_i (rank_q),
    .wdata_i (i_q),
    .raddr_i (k_q),
    .rdata_o (idx_rdata)
  );

  // The key read in the previous cycle belongs to scan position j - 1.
  assign kj              = signed'(key_rdata);
  assign ki              = signed'(keyi_q);
  assign j_m1            = j_q - 1'b1;
  assign strictly_before = descending_i ? (kj > ki) : (kj < ki);
  assign equal_keys      = (key_rdata == keyi_q);
  assign arrived_earlier = (j_m1 < CW'(i_q));
  assign cnt_m1          = cnt_q - 1'b1;

  assign status_o.cmp_last = (j_q == cnt_q);
  assign status_o.i_last   = (CW'(i_q) == cnt_m1);
  assign status_o.k_last   = (CW'(k_q) == cnt_m1);

  always_comb begin
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    rank_d      = rank_q;
    out_valid_d = out_valid_q;
    if (cmd_i.store) begin
      if (cnt_q < MAX_CNT) begin
        cnt_d = cnt_q + 1'b1;
      end else begin
        drop_d = 1'b1;
      end
    end
    if (cmd_i.j_clr) begin
      j_d = '0;
    end else if (cmd_i.j_inc) begin
      j_d = j_q + 1'b1;
    end
    if (cmd_i.rank_clr) begin
      rank_d = '0;
    end else if (cmd_i.cmp_en && (strictly_before || (equal_keys && arrived_earlier))) begin
      rank_d = rank_q + 1'b1;
    end
    if (cmd_i.i_inc) begin
      i_d = i_q + 1'b1;
    end
    if (cmd_i.k_inc) begin
      k_d = k_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (cmd_i.out_clear) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.list_done) begin
      cnt_d  = '0;
      drop_d = 1'b0;
      i_d    = '0;
      k_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      rank_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      rank_q      <= rank_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_key) begin
      keyi_q <= key_rdata;
    end
    if (cmd_i.out_load) begin
      out_idx_q  <= INDEX_W'(idx_rdata);
      out_last_q <= status_o.k_last;
      out_ovf_q  <= drop_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign index_o     = out_idx_q;
  assign last_out_o  = out_last_q;
  assign overflow_o  = out_ovf_q;

endmodule

// ===== rtl/core/sia_ctrl.sv =====
// ----------------------------------------------------------------------------
// sia_ctrl
// Controller: collects keys, sequences the rank scan and the output run.
// ----------------------------------------------------------------------------
module sia_ctrl import sia_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    last_in_i,
  input  logic    out_stall_i,
  input  status_t status_i,
  output logic    in_stall_o,
  output cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOADI = 3'd1;
  localparam logic [2:0] S_LATCH = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_ORD   = 3'd5;
  localparam logic [2:0] S_OLAT  = 3'd6;
  localparam logic [2:0] S_OWAIT = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.store = accept;
        if (accept && last_in_i) begin
          state_d = S_LOADI;
        end
      end
      S_LOADI: begin
        cmd_o.rd_sel_i = 1'b1;
        cmd_o.j_clr    = 1'b1;
        cmd_o.rank_clr = 1'b1;
        state_d        = S_LATCH;
      end
      S_LATCH: begin
        cmd_o.latch_key = 1'b1;
        cmd_o.j_inc     = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.cmp_en = 1'b1;
        cmd_o.j_inc  = 1'b1;
        if (status_i.cmp_last) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.idx_wr = 1'b1;
        cmd_o.i_inc  = 1'b1;
        state_d      = status_i.i_last ? S_ORD : S_LOADI;
      end
      S_ORD: begin
        state_d = S_OLAT;
      end
      S_OLAT: begin
        cmd_o.out_load = 1'b1;
        state_d        = S_OWAIT;
      end
      S_OWAIT: begin
        if (!out_stall_i) begin
          cmd_o.out_clear = 1'b1;
          cmd_o.k_inc     = 1'b1;
          if (status_i.k_last) begin
            cmd_o.list_done = 1'b1;
            state_d         = S_IDLE;
          end else begin
            state_d = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/stable_integer_argsort.sv =====
// ----------------------------------------------------------------------------
// stable_integer_argsort
// Collects a list of signed keys and returns their arrival indices in stable
// sorted order, ascending or descending.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   value_i, last_in_i
//   out      output     out_valid_o / out_stall_i index_o, last_out_o, overflow_o
//   cfg      APB        psel/penable/pwrite/pready paddr, pwdata, prdata
//
// After the last key the block ranks each of the n stored keys against all
// others through the single read port of the key memory. Each result is then
// read from the rank memory, loaded into the output register and held while
// out_stall_i is high. No input is taken during ranking and output. Reset
// clears control state only; the memories need no clearing.
// ----------------------------------------------------------------------------
module stable_integer_argsort import sia_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KEY_W-1:0]   value_i,
  input  logic               last_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [INDEX_W-1:0] index_o,
  output logic               last_out_o,
  output logic               overflow_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  cmd_t    cmd;
  status_t status;
  logic    descending_q;

  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1] == REG_DESCENDING) ?
                  {{(APB_DW-1){1'b0}}, descending_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      descending_q <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[APB_AW-1] == REG_DESCENDING)) begin
      descending_q <= pwdata[0];
    end
  end

  sia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_in_i   (last_in_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  sia_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .value_i      (value_i),
    .descending_i (descending_q),
    .out_valid_o  (out_valid_o),
    .index_o      (index_o),
    .last_out_o   (last_out_o),
    .overflow_o   (overflow_o)
  );

  // Results are only shown while input is held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result shown while input is open");

  // A final item starts the sort and closes the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_in_i) |=> in_stall_o)
    else $error("input still open after final item");

  // Delivering the final result reopens the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_out_o) |=> (!in_stall_o && !out_valid_o))
    else $error("block did not return to idle after the run");

endmodule
